>>> rtl/decimal_accumulator_machine_step_unit_macros.svh
// Assertion macros shared by the decimal accumulator machine RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef DECIMAL_ACCUMULATOR_MACHINE_STEP_UNIT_MACROS_SVH
`define DECIMAL_ACCUMULATOR_MACHINE_STEP_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DAM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
`define DAM_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");
`else
`define DAM_ASSERT(name, prop)
`define DAM_ASSERT_NEXT(name, pre, post)
`endif
`endif

>>> rtl/dam_pkg.sv
// Package for the decimal accumulator machine: widths, codes and the
// request/response structs between the sequencer, memory and arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps

package dam_pkg;

  localparam int MEM_WORDS   = 100;
  localparam int WORD_LIMIT  = 9999;
  localparam int WORD_W      = 15;
  localparam int MAG_W       = WORD_W - 1;
  localparam int ADDR_W      = 7;
  localparam int OP_W        = 8;
  localparam int CNT_W       = $clog2(WORD_W);
  localparam int OPCODE_BASE = 100;

  // floor(w / 100) = (w * 5243) >> 19 for every 14-bit w
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = RECIP_SHIFT + OP_W;

  localparam int IN_DATA_W   = 24;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 56;
  localparam int OUT_USER_W  = 1;

  localparam logic signed [WORD_W-1:0] WORD_MAX = WORD_W'(WORD_LIMIT);
  localparam logic signed [WORD_W-1:0] WORD_MIN = -WORD_MAX;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_EXEC    = 2'd1,
    ACT_READ    = 2'd2,
    ACT_RESTART = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_HALT     = 3'd1,
    ST_DIVZERO  = 3'd2,
    ST_BADOP    = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_COUNTER  = 3'd5
  } status_e;

  typedef enum logic [OP_W-1:0] {
    OP_READ     = 8'd10,
    OP_WRITE    = 8'd11,
    OP_LOAD     = 8'd20,
    OP_STORE    = 8'd21,
    OP_ADD      = 8'd30,
    OP_SUB      = 8'd31,
    OP_DIV      = 8'd32,
    OP_MUL      = 8'd33,
    OP_BRANCH   = 8'd40,
    OP_BRNEG    = 8'd41,
    OP_BRZERO   = 8'd42,
    OP_HALT     = 8'd43
  } opcode_e;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] wr_data;
  } mem_req_t;

  typedef struct packed {
    logic              start;
    logic              op_div;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [WORD_W-1:0] value;
  } md_res_t;

endpackage

>>> rtl/dam_mem.sv
// Program/data memory of the decimal accumulator machine: one write and one
// registered read port, per-word valid bits so unwritten words read as zero.
// Depends on dam_pkg.
`timescale 1ns / 1ps

module dam_mem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dam_pkg::mem_req_t         req_i,
  output logic [dam_pkg::WORD_W-1:0] rd_data_o
);

  logic [dam_pkg::WORD_W-1:0]    mem_q [dam_pkg::MEM_WORDS];
  logic [dam_pkg::MEM_WORDS-1:0] vld_q;
  logic [dam_pkg::WORD_W-1:0]    rd_word_q;
  logic                          rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_word_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_word_q : '0;

endmodule

>>> rtl/dam_muldiv.sv
// Shared iterative multiply/divide unit: one adder serves shift-add multiply
// and restoring divide on sign-magnitude words, one bit per cycle.
// Depends on dam_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "decimal_accumulator_machine_step_unit_macros.svh"

module dam_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dam_pkg::md_req_t req_i,
  output dam_pkg::md_res_t res_o
);

  localparam int W  = dam_pkg::WORD_W;
  localparam int RW = 2 * W;
  localparam logic [dam_pkg::CNT_W-1:0] LAST_STEP = dam_pkg::CNT_W'(W - 1);

  logic                     busy_q;
  logic                     done_q;
  logic [dam_pkg::CNT_W-1:0] cnt_q;
  logic                     div_q;
  logic                     neg_q;
  logic [RW-1:0]            ra_q;
  logic [RW-1:0]            rb_q;
  logic [W-1:0]             rc_q;

  logic [W-1:0]  a_mag;
  logic [W-1:0]  b_mag;
  logic [RW-1:0] add_x;
  logic [RW-1:0] add_y;
  logic [RW:0]   add_sum;
  logic [W-1:0]  res_mag;

  assign a_mag = req_i.a[W-1] ? W'(-req_i.a) : req_i.a;
  assign b_mag = req_i.b[W-1] ? W'(-req_i.b) : req_i.b;

  assign add_x   = div_q ? {{(RW-W-1){1'b0}}, ra_q[W-1:0], rc_q[W-1]} : ra_q;
  assign add_y   = div_q ? ~rb_q : rb_q;
  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + (RW+1)'(div_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      div_q <= req_i.op_div;
      neg_q <= req_i.a[W-1] ^ req_i.b[W-1];
      ra_q  <= '0;
      rb_q  <= RW'(req_i.op_div ? b_mag : a_mag);
      rc_q  <= req_i.op_div ? a_mag : b_mag;
    end else if (busy_q) begin
      if (div_q) begin
        ra_q <= RW'(add_sum[RW] ? add_sum[W-1:0] : add_x[W-1:0]);
        rc_q <= {rc_q[W-2:0], add_sum[RW]};
      end else begin
        if (rc_q[0]) begin
          ra_q <= add_sum[RW-1:0];
        end
        rb_q <= {rb_q[RW-2:0], 1'b0};
        rc_q <= {1'b0, rc_q[W-1:1]};
      end
    end
  end

  assign res_mag      = div_q ? rc_q : ra_q[W-1:0];
  assign res_o.done   = done_q;
  assign res_o.ovf    = !div_q && (ra_q > RW'(dam_pkg::WORD_LIMIT));
  assign res_o.value  = neg_q ? W'(-res_mag) : res_mag;

  `DAM_ASSERT(a_start_when_free, req_i.start |-> !busy_q)
  `DAM_ASSERT_NEXT(a_done_after_last, busy_q && (cnt_q == LAST_STEP), done_q)
  `DAM_ASSERT(a_done_not_busy, done_q |-> !busy_q)

endmodule

>>> rtl/decimal_accumulator_machine_step_unit.sv
// Top level of the decimal accumulator machine: stream ports, sequencer,
// architectural registers and the result register.
// Depends on dam_pkg, dam_mem, dam_muldiv and the assertion macro header.
//
//   port group   direction  tdata fields (low bit up)                    tuser
//   s_axis       in         address[6:0] value[21:7]                      action[1:0]
//   m_axis       out        status[2:0] out_value[17:3] counter[24:18]    out_valid[0]
//                           acc_value[39:25] last_instruction[54:40]
//
// Load and restart go straight to the final state, read via the read-wait state, an
// instruction via fetch, decode and operand, mul/div also via the 15-step shared unit.
// s_axis_tready is high only while the sequencer waits for a transaction.
// A finished result holds in the output register until taken; the next
// transaction is accepted meanwhile and its result waits in the final state.
// Reset clears the word valid bits, so memory reads as zero at once.
`timescale 1ns / 1ps
`include "decimal_accumulator_machine_step_unit_macros.svh"

module decimal_accumulator_machine_step_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [dam_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // address, value
  input  logic [dam_pkg::IN_USER_W-1:0]    s_axis_tuser,  // action
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status, out_value, counter, acc_value, last_instruction
  output logic [dam_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [dam_pkg::OUT_USER_W-1:0]   m_axis_tuser   // out_valid
);

  localparam int W  = dam_pkg::WORD_W;
  localparam int AW = dam_pkg::ADDR_W;
  localparam logic [AW-1:0] PC_LAST = AW'(dam_pkg::MEM_WORDS - 1);
  localparam logic signed [W:0] LIM_HI = (W+1)'(dam_pkg::WORD_LIMIT);
  localparam logic signed [W:0] LIM_LO = -LIM_HI;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_RDWAIT  = 7'b0000010,
    S_FETCH   = 7'b0000100,
    S_DECODE  = 7'b0001000,
    S_OPERAND = 7'b0010000,
    S_ITER    = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_e;

  function automatic logic signed [W-1:0] sat_word(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    r = v;
    if (v > dam_pkg::WORD_MAX) begin
      r = dam_pkg::WORD_MAX;
    end else if (v < dam_pkg::WORD_MIN) begin
      r = dam_pkg::WORD_MIN;
    end
    return r;
  endfunction

  state_e                          state_q, state_d;
  logic signed [W-1:0]             acc_q, acc_d;
  logic [AW-1:0]                   pc_q, pc_d;
  logic signed [W-1:0]             ir_q, ir_d;
  dam_pkg::status_e                status_q, status_d;
  logic signed [W-1:0]             value_q, value_d;
  logic [dam_pkg::RECIP_W-1:0]     recip_q, recip_d;
  logic [dam_pkg::OP_W-1:0]        op_q, op_d;
  logic [AW-1:0]                   opa_q, opa_d;
  logic                            res_valid_q, res_valid_d;
  logic signed [W-1:0]             res_value_q, res_value_d;
  logic                            m_tvalid_q;
  logic [dam_pkg::OUT_DATA_W-1:0]  out_data_q;
  logic [dam_pkg::OUT_USER_W-1:0]  out_user_q;

  dam_pkg::mem_req_t               mem_req;
  logic [W-1:0]                    mem_rd_data;
  dam_pkg::md_req_t                md_req;
  dam_pkg::md_res_t                md_res;

  logic                            in_acc;
  dam_pkg::action_e                in_act;
  logic [AW-1:0]                   in_addr;
  logic signed [W-1:0]             in_value;
  logic                            in_addr_ok;
  logic signed [W-1:0]             opnd;
  logic [dam_pkg::OP_W-1:0]        dec_op;
  logic [dam_pkg::MAG_W-1:0]       dec_opx100;
  logic [AW-1:0]                   dec_addr;
  logic signed [W:0]               sum_ext;
  logic                            sum_ok;
  logic                            do_adv;
  logic                            out_load;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign in_act     = dam_pkg::action_e'(s_axis_tuser);
  assign in_addr    = s_axis_tdata[AW-1:0];
  assign in_value   = signed'(s_axis_tdata[AW+W-1:AW]);
  assign in_addr_ok = (in_addr <= PC_LAST);

  assign opnd       = signed'(mem_rd_data);
  assign dec_op     = recip_q[dam_pkg::RECIP_SHIFT +: dam_pkg::OP_W];
  assign dec_opx100 = dam_pkg::MAG_W'(dec_op) * dam_pkg::MAG_W'(dam_pkg::OPCODE_BASE);
  assign dec_addr   = AW'(ir_q[dam_pkg::MAG_W-1:0] - dec_opx100);

  assign sum_ext = (op_q == dam_pkg::OP_SUB) ? ({acc_q[W-1], acc_q} - {opnd[W-1], opnd})
                                             : ({acc_q[W-1], acc_q} + {opnd[W-1], opnd});
  assign sum_ok  = (sum_ext <= LIM_HI) && (sum_ext >= LIM_LO);

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    pc_d        = pc_q;
    ir_d        = ir_q;
    status_d    = status_q;
    value_d     = value_q;
    recip_d     = recip_q;
    op_d        = op_q;
    opa_d       = opa_q;
    res_valid_d = res_valid_q;
    res_value_d = res_value_q;
    mem_req     = '0;
    md_req      = '0;
    md_req.a    = acc_q;
    md_req.b    = opnd;
    do_adv      = 1'b0;
    out_load    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_valid_d = 1'b0;
          res_value_d = '0;
          value_d     = sat_word(in_value);
          state_d     = S_FINISH;
          unique case (in_act)
            dam_pkg::ACT_LOAD: begin
              mem_req.wr_en   = in_addr_ok;
              mem_req.wr_addr = in_addr;
              mem_req.wr_data = sat_word(in_value);
            end
            dam_pkg::ACT_EXEC: begin
              if (status_q == dam_pkg::ST_OK) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = pc_q;
                state_d         = S_FETCH;
              end
            end
            dam_pkg::ACT_READ: begin
              if (in_addr_ok) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = in_addr;
                res_valid_d     = 1'b1;
                state_d         = S_RDWAIT;
              end
            end
            dam_pkg::ACT_RESTART: begin
              pc_d     = '0;
              acc_d    = '0;
              ir_d     = '0;
              status_d = dam_pkg::ST_OK;
            end
          endcase
        end
      end

      S_RDWAIT: begin
        res_value_d = opnd;
        state_d     = S_FINISH;
      end

      S_FETCH: begin
        ir_d = opnd;
        if (opnd[W-1]) begin
          status_d = dam_pkg::ST_BADOP;
          state_d  = S_FINISH;
        end else begin
          recip_d = dam_pkg::RECIP_W'(mem_rd_data[dam_pkg::MAG_W-1:0])
                  * dam_pkg::RECIP_W'(dam_pkg::RECIP_100);
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        op_d            = dec_op;
        opa_d           = dec_addr;
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = dec_addr;
        state_d         = S_OPERAND;
      end

      S_OPERAND: begin
        state_d = S_FINISH;
        unique case (op_q)
          dam_pkg::OP_READ: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = opa_q;
            mem_req.wr_data = value_q;
            do_adv          = 1'b1;
          end
          dam_pkg::OP_WRITE: begin
            res_valid_d = 1'b1;
            res_value_d = opnd;
            do_adv      = 1'b1;
          end
          dam_pkg::OP_LOAD: begin
            acc_d  = opnd;
            do_adv = 1'b1;
          end
          dam_pkg::OP_STORE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = opa_q;
            mem_req.wr_data = acc_q;
            do_adv          = 1'b1;
          end
          dam_pkg::OP_ADD, dam_pkg::OP_SUB: begin
            if (sum_ok) begin
              acc_d  = W'(sum_ext);
              do_adv = 1'b1;
            end else begin
              status_d = dam_pkg::ST_OVERFLOW;
            end
          end
          dam_pkg::OP_DIV: begin
            if (opnd == '0) begin
              status_d = dam_pkg::ST_DIVZERO;
            end else begin
              md_req.start  = 1'b1;
              md_req.op_div = 1'b1;
              state_d       = S_ITER;
            end
          end
          dam_pkg::OP_MUL: begin
            md_req.start = 1'b1;
            state_d      = S_ITER;
          end
          dam_pkg::OP_BRANCH: begin
            pc_d = opa_q;
          end
          dam_pkg::OP_BRNEG: begin
            if (acc_q[W-1]) begin
              pc_d = opa_q;
            end else begin
              do_adv = 1'b1;
            end
          end
          dam_pkg::OP_BRZERO: begin
            if (acc_q == '0) begin
              pc_d = opa_q;
            end else begin
              do_adv = 1'b1;
            end
          end
          dam_pkg::OP_HALT: begin
            status_d = dam_pkg::ST_HALT;
          end
          default: begin
            status_d = dam_pkg::ST_BADOP;
          end
        endcase
      end

      S_ITER: begin
        if (md_res.done) begin
          state_d = S_FINISH;
          if (md_res.ovf) begin
            status_d = dam_pkg::ST_OVERFLOW;
          end else begin
            acc_d  = signed'(md_res.value);
            do_adv = 1'b1;
          end
        end
      end

      S_FINISH: begin
        if (!m_tvalid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (do_adv) begin
      if (pc_q == PC_LAST) begin
        status_d = dam_pkg::ST_COUNTER;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      pc_q        <= '0;
      ir_q        <= '0;
      status_q    <= dam_pkg::ST_OK;
      res_valid_q <= 1'b0;
      m_tvalid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      pc_q        <= pc_d;
      ir_q        <= ir_d;
      status_q    <= status_d;
      res_valid_q <= res_valid_d;
      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q     <= value_d;
    recip_q     <= recip_d;
    op_q        <= op_d;
    opa_q       <= opa_d;
    res_value_q <= res_value_d;
    if (out_load) begin
      out_data_q <= {1'b0, ir_q, acc_q, pc_q, res_value_q, status_q};
      out_user_q <= res_valid_q;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  dam_mem u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .rd_data_o(mem_rd_data)
  );

  dam_muldiv u_muldiv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (md_req),
    .res_o (md_res)
  );

  `DAM_ASSERT(a_counter_range, pc_q <= PC_LAST)
  `DAM_ASSERT(a_acc_range, (acc_q <= dam_pkg::WORD_MAX) && (acc_q >= dam_pkg::WORD_MIN))
  `DAM_ASSERT(a_out_from_finish, $rose(m_axis_tvalid) |-> $past(state_q == S_FINISH))
  `DAM_ASSERT(a_iter_running, (state_q == S_ITER) |-> (status_q == dam_pkg::ST_OK))
  `DAM_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

>>> bench/dam_step_checker.sv
`timescale 1ns / 1ps
// Checker for the decimal accumulator machine step unit: watches both stream
// channels, steps its own copy of the machine per input transaction and
// compares each result field by field. Depends on dam_pkg.

module dam_step_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [dam_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // address, value
  input  logic [dam_pkg::IN_USER_W-1:0]  s_axis_tuser,   // action
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status, out_value, counter, acc_value, last_instruction
  input  logic [dam_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [dam_pkg::OUT_USER_W-1:0] m_axis_tuser,   // out_valid
  output int                             fail_count_o,
  output int                             pending_o
);
  import dam_pkg::*;

  typedef struct packed {
    status_e           status;
    logic              out_valid;
    logic [WORD_W-1:0] out_value;
    logic [ADDR_W-1:0] counter;
    logic [WORD_W-1:0] acc_value;
    logic [WORD_W-1:0] last_instr;
  } step_result_t;

  int           mem_words [MEM_WORDS];
  int           acc_q;
  int           pc_q;
  int           ir_q;
  status_e      run_st;
  step_result_t pending_results [$];

  function automatic int clamp_word(input int v);
    if (v > WORD_LIMIT) return WORD_LIMIT;
    if (v < -WORD_LIMIT) return -WORD_LIMIT;
    return v;
  endfunction

  task automatic reset_machine();
    for (int i = 0; i < MEM_WORDS; i++) mem_words[i] = 0;
    acc_q  = 0;
    pc_q   = 0;
    ir_q   = 0;
    run_st = ST_OK;
    pending_results.delete();
  endtask

  task automatic advance_counter();
    if (pc_q + 1 >= MEM_WORDS) run_st = ST_COUNTER;
    else pc_q++;
  endtask

  task automatic run_machine_step(input action_e act, input int addr, input int value,
                                  output step_result_t res);
    int              word;
    int              opa;
    int              m;
    int              r;
    int              ov;
    logic            wr;
    logic [OP_W-1:0] opc;
    wr = 1'b0;
    ov = 0;
    case (act)
      ACT_LOAD: begin
        if (addr < MEM_WORDS) mem_words[addr] = clamp_word(value);
      end
      ACT_EXEC: begin
        if (run_st == ST_OK) begin
          if (pc_q >= MEM_WORDS) begin
            run_st = ST_COUNTER;
          end else begin
            word = mem_words[pc_q];
            ir_q = word;
            if (word < 0) begin
              run_st = ST_BADOP;
            end else begin
              opc = OP_W'(word / OPCODE_BASE);
              opa = word % OPCODE_BASE;
              m   = mem_words[opa];
              case (opc)
                OP_READ: begin
                  mem_words[opa] = clamp_word(value);
                  advance_counter();
                end
                OP_WRITE: begin
                  wr = 1'b1;
                  ov = m;
                  advance_counter();
                end
                OP_LOAD: begin
                  acc_q = m;
                  advance_counter();
                end
                OP_STORE: begin
                  mem_words[opa] = acc_q;
                  advance_counter();
                end
                OP_ADD, OP_SUB, OP_MUL: begin
                  if (opc == OP_ADD) r = acc_q + m;
                  else if (opc == OP_SUB) r = acc_q - m;
                  else r = acc_q * m;
                  if (r > WORD_LIMIT || r < -WORD_LIMIT) begin
                    run_st = ST_OVERFLOW;
                  end else begin
                    acc_q = r;
                    advance_counter();
                  end
                end
                OP_DIV: begin
                  if (m == 0) begin
                    run_st = ST_DIVZERO;
                  end else begin
                    acc_q = acc_q / m;
                    advance_counter();
                  end
                end
                OP_BRANCH: pc_q = opa;
                OP_BRNEG: begin
                  if (acc_q < 0) pc_q = opa;
                  else advance_counter();
                end
                OP_BRZERO: begin
                  if (acc_q == 0) pc_q = opa;
                  else advance_counter();
                end
                OP_HALT: run_st = ST_HALT;
                default: run_st = ST_BADOP;
              endcase
            end
          end
        end
      end
      ACT_READ: begin
        if (addr < MEM_WORDS) begin
          wr = 1'b1;
          ov = mem_words[addr];
        end
      end
      default: begin
        pc_q   = 0;
        acc_q  = 0;
        ir_q   = 0;
        run_st = ST_OK;
      end
    endcase
    res.status     = run_st;
    res.out_valid  = wr;
    res.out_value  = wr ? WORD_W'(ov) : '0;
    res.counter    = ADDR_W'(pc_q);
    res.acc_value  = WORD_W'(acc_q);
    res.last_instr = WORD_W'(ir_q);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    step_result_t got;
    step_result_t want;
    step_result_t res;
    if (!rst_ni) begin
      reset_machine();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status     = status_e'(m_axis_tdata[2:0]);
        got.out_value  = m_axis_tdata[17:3];
        got.counter    = m_axis_tdata[24:18];
        got.acc_value  = m_axis_tdata[39:25];
        got.last_instr = m_axis_tdata[54:40];
        got.out_valid  = m_axis_tuser[0];
        if (pending_results.size() == 0) begin
          $error("result transaction with no input transaction waiting");
          fail_count_o++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", int'(want.status), int'(got.status));
          check_field("out_valid", int'(want.out_valid), int'(got.out_valid));
          check_field("out_value", int'($signed(want.out_value)),
                      int'($signed(got.out_value)));
          check_field("counter", int'(want.counter), int'(got.counter));
          check_field("acc_value", int'($signed(want.acc_value)),
                      int'($signed(got.acc_value)));
          check_field("last_instruction", int'($signed(want.last_instr)),
                      int'($signed(got.last_instr)));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        run_machine_step(action_e'(s_axis_tuser), int'(s_axis_tdata[6:0]),
                         int'($signed(s_axis_tdata[21:7])), res);
        pending_results.push_back(res);
      end
    end
    pending_o = pending_results.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the decimal accumulator machine bench: clock, reset, stimulus on the
// input stream, back-pressure on the result stream and the verdict.
// Depends on dam_pkg, the step unit and dam_step_checker.

module tb_top;
  import dam_pkg::*;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  int fail_count;
  int pending_count;
  bit calm = 1'b0;
  int n_items;
  int n_runs;
  int n_noise;
  int n_directed;

  opcode_e op_tbl [12] = '{OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB,
                           OP_DIV, OP_MUL, OP_BRANCH, OP_BRNEG, OP_BRZERO, OP_HALT};

  always #5 clk_i = ~clk_i;

  decimal_accumulator_machine_step_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  dam_step_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int instr(input opcode_e op, input int a);
    return int'(op) * OPCODE_BASE + a;
  endfunction

  function automatic int rand_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return int'($urandom_range(0, 40)) - 20;
    if (r < 60) return int'($urandom_range(0, 19998)) - WORD_LIMIT;
    if (r < 72) return 0;
    if (r < 84) return ($urandom_range(0, 1) != 0) ? WORD_LIMIT : -WORD_LIMIT;
    return int'($urandom_range(0, 32767));
  endfunction

  function automatic int make_instr(input int len);
    int unsigned r;
    int          target;
    opcode_e     op;
    r = $urandom_range(0, 99);
    if (r < 3) return -int'($urandom_range(1, WORD_LIMIT));
    if (r < 6) return int'($urandom_range(0, 999));
    if (r < 8) return int'($urandom_range(44, 99)) * OPCODE_BASE + int'($urandom_range(0, 99));
    op = op_tbl[$urandom_range(0, 11)];
    case (op)
      OP_BRANCH, OP_BRNEG, OP_BRZERO: begin
        if ($urandom_range(0, 4) == 0) target = $urandom_range(95, 99);
        else target = $urandom_range(0, len - 1);
      end
      default: begin
        if ($urandom_range(0, 7) == 0) target = $urandom_range(0, 99);
        else target = $urandom_range(80, 94);
      end
    endcase
    return instr(op, target);
  endfunction

  task automatic send_item(input action_e act, input int addr, input int value);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, 15'(value), 7'(addr)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_items++;
  endtask

  task automatic send_noise(input int count);
    repeat (count) begin
      send_item(action_e'($urandom_range(0, 3)), $urandom_range(0, 127),
                $urandom_range(0, 32767));
      n_noise++;
    end
  endtask

  // restart in most runs, load a short program and some data, then step it amid reads and noise
  task automatic run_program();
    int          len;
    int unsigned r;
    len = $urandom_range(3, 14);
    if ($urandom_range(0, 7) != 0)
      send_item(ACT_RESTART, $urandom_range(0, 127), $urandom_range(0, 32767));
    for (int k = 0; k < len; k++) send_item(ACT_LOAD, k, make_instr(len));
    if ($urandom_range(0, 3) == 0)
      for (int k = 95; k < MEM_WORDS; k++) send_item(ACT_LOAD, k, make_instr(len));
    repeat ($urandom_range(2, 6)) send_item(ACT_LOAD, $urandom_range(80, 94), rand_word());
    repeat ($urandom_range(4, 30)) begin
      r = $urandom_range(0, 9);
      if (r == 0) send_item(ACT_READ, $urandom_range(0, 99), rand_word());
      else if (r == 1) send_noise(1);
      else send_item(ACT_EXEC, $urandom_range(0, 127), rand_word());
    end
    n_runs++;
  endtask

  initial begin : stimulus
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(ACT_LOAD, 99, 16383);
    send_item(ACT_LOAD, 98, -16384);
    send_item(ACT_LOAD, 127, 32767);
    send_item(ACT_READ, 127, 32767);
    send_item(ACT_LOAD, 0, instr(OP_READ, 90));
    send_item(ACT_LOAD, 1, instr(OP_LOAD, 90));
    send_item(ACT_LOAD, 2, instr(OP_BRNEG, 4));
    send_item(ACT_LOAD, 4, instr(OP_DIV, 90));
    send_item(ACT_LOAD, 5, instr(OP_MUL, 90));
    send_item(ACT_LOAD, 6, instr(OP_SUB, 90));
    send_item(ACT_LOAD, 7, instr(OP_BRZERO, 9));
    send_item(ACT_LOAD, 9, instr(OP_STORE, 91));
    send_item(ACT_LOAD, 10, instr(OP_WRITE, 90));
    send_item(ACT_LOAD, 11, instr(OP_DIV, 91));
    send_item(ACT_EXEC, 0, -16384);
    repeat (10) send_item(ACT_EXEC, 0, 0);
    send_item(ACT_RESTART, 127, 32767);
    send_item(ACT_LOAD, 0, instr(OP_BRANCH, 99));
    send_item(ACT_LOAD, 99, instr(OP_LOAD, 98));
    repeat (2) send_item(ACT_EXEC, 0, 0);
    n_directed = n_items;

    while (n_items < n_directed + 1250) begin
      calm = (n_runs % 10 == 5);
      run_program();
      if ($urandom_range(0, 4) == 0) send_noise($urandom_range(3, 8));
    end
    calm = 1'b0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (pending_count != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    $display("covered %0d input transactions: %0d directed, %0d program runs, %0d noise",
             n_items, n_directed, n_runs, n_noise);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin : receiver
    int unsigned gap;
    int unsigned burst;
    int          cyc;
    bit          held;
    cyc  = 0;
    held = 1'b0;
    forever begin
      if (!held && cyc >= 3000) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (499) @(negedge clk_i);
        cyc += 500;
        held = 1'b1;
      end
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
        cyc += gap;
      end
      burst = $urandom_range(1, 12);
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      repeat (burst - 1) @(negedge clk_i);
      cyc += burst;
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
